[rtl/spp_pkg.sv]
// ----------------------------------------------------------------------------
// spp_pkg: shared types and constants for the probability sort and prune block
// Field widths, the default frame capacity and the stored entry layout.
// ----------------------------------------------------------------------------
package spp_pkg;

  // Probability width: unsigned fixed point, 32768 stands for 1.0.
  localparam int PROB_W = 16;

  // Symbol number width: one-based arrival position.
  localparam int SYM_W = 7;

  // Default frame capacity.
  localparam int MAX_SYMBOLS_DEF = 32;

  // One stored entry: probability and its symbol number.
  typedef struct packed {
    logic [PROB_W-1:0] value;
    logic [SYM_W-1:0]  symbol;
  } entry_t;

endpackage

[rtl/spp_if.sv]
// ----------------------------------------------------------------------------
// spp channel interfaces
// Valid/ready channels for input beats, result beats and threshold writes.
// ----------------------------------------------------------------------------

// Input channel: one probability per beat.
interface spp_in_if;
  logic                      valid;
  logic                      ready;
  logic [spp_pkg::PROB_W-1:0] prob;
  logic                      frame_end;

  modport source (output valid, output prob, output frame_end, input ready);
  modport sink   (input valid, input prob, input frame_end, output ready);
endinterface

// Result channel: one kept probability per beat.
interface spp_out_if;
  logic                      valid;
  logic                      ready;
  logic [spp_pkg::PROB_W-1:0] out_prob;
  logic [spp_pkg::SYM_W-1:0]  out_symbol;
  logic                      run_end;
  logic                      empty_res;

  modport source (output valid, output out_prob, output out_symbol,
                  output run_end, output empty_res, input ready);
  modport sink   (input valid, input out_prob, input out_symbol,
                  input run_end, input empty_res, output ready);
endinterface

// Configuration channel: prune threshold write data.
interface spp_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [spp_pkg::PROB_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/sort_and_prune_probabilities.sv]
// The block takes input beats only between frames, while the sequencer is idle.
// After the frame end beat, the sort runs for n >= 2 held entries, with one
// compare per cycle through the single memory read port; one entry skips it.
// Reset (rst_n low, synchronous) clears the sequencer, the fill count, the
// result valid and the prune threshold; memory contents are not cleared.
// ----------------------------------------------------------------------------
// sort_and_prune_probabilities: descending exchange sort with threshold prune
// Collects a frame of probabilities, sorts it with the exchange order and
// emits every entry at or above the prune threshold, or an empty marker.
// ----------------------------------------------------------------------------
module sort_and_prune_probabilities #(
  parameter int MAX_SYMBOLS = spp_pkg::MAX_SYMBOLS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spp_in_if.sink    in_ch,
  spp_out_if.source out_ch,
  spp_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(MAX_SYMBOLS);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PRIME,
    S_SCAN,
    S_TAIL,
    S_EREAD,
    S_ECHK,
    S_EFIN
  } state_t;

  state_t                      state_r;
  logic [CW-1:0]               fill_r;
  logic [AW-1:0]               last_r;
  logic [AW-1:0]               i_r;
  logic [AW-1:0]               j_r;
  logic [AW-1:0]               k_r;
  spp_pkg::entry_t             cur_r;
  spp_pkg::entry_t             pend_r;
  logic                        pend_vld_r;
  logic [spp_pkg::PROB_W-1:0]  thr_r;

  logic                        out_valid_r;
  logic [spp_pkg::PROB_W-1:0]  out_prob_r;
  logic [spp_pkg::SYM_W-1:0]   out_symbol_r;
  logic                        out_end_r;
  logic                        out_empty_r;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  spp_pkg::entry_t             wr_data;
  logic [AW-1:0]               rd_addr;
  spp_pkg::entry_t             rd_data;

  logic                        in_fire;
  logic                        has_room;
  logic [CW-1:0]               fill_new;
  logic                        swap;
  logic                        pass;
  logic                        out_free;
  logic                        out_load;

  // Frame entry memory.
  spp_store #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Handshake and shared compare unit.
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign has_room     = (fill_r < CW'(MAX_SYMBOLS));
  assign fill_new     = has_room ? (fill_r + CW'(1)) : fill_r;
  assign swap         = (cur_r.value < rd_data.value);
  assign pass         = (rd_data.value >= thr_r);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // The result register takes a new beat when a kept entry is handed on or
  // the frame closes, and only while it is free.
  assign out_load = out_free && (((state_r == S_ECHK) && pass && pend_vld_r) ||
                                 (state_r == S_EFIN));

  // Memory port control per sequencer step.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i_r;
    wr_data = cur_r;
    rd_addr = k_r;
    unique case (state_r)
      S_IDLE: begin
        wr_en          = in_fire && has_room;
        wr_addr        = fill_r[AW-1:0];
        wr_data.value  = in_ch.prob;
        wr_data.symbol = spp_pkg::SYM_W'(fill_r) + spp_pkg::SYM_W'(1);
      end
      S_START: begin
        rd_addr = '0;
      end
      S_PRIME: begin
        rd_addr = i_r + AW'(1);
      end
      S_SCAN: begin
        wr_en   = swap;
        wr_addr = j_r;
        rd_addr = j_r + AW'(1);
      end
      S_TAIL: begin
        wr_en   = 1'b1;
        rd_addr = i_r + AW'(1);
      end
      S_EREAD, S_ECHK, S_EFIN: begin
        rd_addr = k_r;
      end
      default: begin
        rd_addr = k_r;
      end
    endcase
  end

  // Sequencer, sort registers, threshold and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= '0;
    end else begin
      if (cfg_ch.valid) begin
        thr_r <= cfg_ch.data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        // Load beats until the frame end.
        S_IDLE: begin
          if (in_fire) begin
            fill_r <= fill_new;
            if (in_ch.frame_end) begin
              last_r     <= AW'(fill_new - CW'(1));
              i_r        <= '0;
              k_r        <= '0;
              pend_vld_r <= 1'b0;
              state_r    <= (fill_new > CW'(1)) ? S_START : S_EREAD;
            end
          end
        end
        // Fetch entry 0 to begin the first pass.
        S_START: begin
          state_r <= S_PRIME;
        end
        // Latch entry i as the running maximum and fetch entry i + 1.
        S_PRIME: begin
          cur_r   <= rd_data;
          j_r     <= i_r + AW'(1);
          state_r <= S_SCAN;
        end
        // Compare entry j against the running maximum, exchanging when the maximum is smaller.
        S_SCAN: begin
          if (swap) begin
            cur_r <= rd_data;
          end
          if (j_r == last_r) begin
            state_r <= S_TAIL;
          end else begin
            j_r <= j_r + AW'(1);
          end
        end
        // Store the maximum at position i and move on to the next pass.
        S_TAIL: begin
          i_r <= i_r + AW'(1);
          if ((i_r + AW'(1)) == last_r) begin
            state_r <= S_EREAD;
          end else begin
            state_r <= S_PRIME;
          end
        end
        // Fetch sorted entry k.
        S_EREAD: begin
          state_r <= S_ECHK;
        end
        // Keep passing entries; the previous kept one goes out as a beat.
        S_ECHK: begin
          if (!pass || !pend_vld_r || out_free) begin
            if (pass) begin
              if (pend_vld_r) begin
                out_prob_r   <= pend_r.value;
                out_symbol_r <= pend_r.symbol;
                out_end_r    <= 1'b0;
                out_empty_r  <= 1'b0;
              end
              pend_r     <= rd_data;
              pend_vld_r <= 1'b1;
            end
            if (k_r == last_r) begin
              state_r <= S_EFIN;
            end else begin
              k_r     <= k_r + AW'(1);
              state_r <= S_EREAD;
            end
          end
        end
        // Final beat of the frame, or the empty marker.
        S_EFIN: begin
          if (out_free) begin
            out_end_r    <= 1'b1;
            if (pend_vld_r) begin
              out_prob_r   <= pend_r.value;
              out_symbol_r <= pend_r.symbol;
              out_empty_r  <= 1'b0;
            end else begin
              out_prob_r   <= '0;
              out_symbol_r <= '0;
              out_empty_r  <= 1'b1;
            end
            fill_r  <= '0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result channel outputs.
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_prob   = out_prob_r;
  assign out_ch.out_symbol = out_symbol_r;
  assign out_ch.run_end    = out_end_r;
  assign out_ch.empty_res  = out_empty_r;

endmodule

[rtl/spp_store.sv]
// ----------------------------------------------------------------------------
// spp_store: frame entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spp_store #(
  parameter int MAX_SYMBOLS = spp_pkg::MAX_SYMBOLS_DEF,
  localparam int AW = $clog2(MAX_SYMBOLS)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  spp_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output spp_pkg::entry_t rd_data
);

  spp_pkg::entry_t mem [MAX_SYMBOLS];
  spp_pkg::entry_t rd_data_r;

  // Write port and registered read port; a read returns the stored entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
